### src/healpix_mesh_node_neighbour_index_unit_defines.svh
// assertion helpers shared by the rtl
`ifndef HEALPIX_MESH_NODE_NEIGHBOUR_INDEX_UNIT_DEFINES_SVH
`define HEALPIX_MESH_NODE_NEIGHBOUR_INDEX_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HMNI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define HMNI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/hmni_pkg.sv
package hmni_pkg;

   localparam int OP_W        = 2;
   localparam int COL_W       = 13;
   localparam int ROW_W       = 13;
   localparam int NSIDE_W     = 11;
   localparam int VIDX_W      = 25;
   localparam int DVS_W       = 11;
   localparam int REM_W       = DVS_W;
   localparam int CST_W       = 6;
   localparam int CMP_W       = 16;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic [OP_W-1:0] {
      OP_NODE  = 2'd0,
      OP_UPPER = 2'd1,
      OP_LOWER = 2'd2,
      OP_RIGHT = 2'd3
   } hmni_op_type;

   // polynomial part of the index, in n*n, n*row, row*row, n and row
   typedef enum logic [3:0] {
      F_ZERO,
      F_POLE,
      F_GHOST,
      F_POLAR_N,
      F_EQ_N,
      F_S_N,
      F_UP_N,
      F_UP_NS,
      F_UP_EQ,
      F_UP_S,
      F_LO_N,
      F_LO_EQ,
      F_LO_S
   } hmni_form_type;

   typedef enum logic [2:0] {
      X_ZERO,
      X_ONE,
      X_TWO,
      X_HALF,
      X_HALF_UP
   } hmni_xsel_type;

   typedef enum logic [1:0] {
      Q_NONE,
      Q_ADD,
      Q_SUB
   } hmni_qop_type;

   typedef struct packed {
      hmni_form_type      form;
      hmni_xsel_type      xsel;
      logic [CST_W-1:0]   cst;
      hmni_qop_type       qop;
      logic [DVS_W-1:0]   dvs;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [NSIDE_W-1:0] nside;
      logic               err;
   } hmni_item_type;

endpackage

### src/hmni_front.sv
module hmni_front #(
   parameter int MAX_NSIDE = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hmni_pkg::NSIDE_W-1:0]        csr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hmni_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [hmni_pkg::OP_W-1:0]           req_tuser,
   input  logic                                q_full,
   output logic                                q_push,
   output hmni_pkg::hmni_item_type             q_item
);
   import hmni_pkg::*;

   logic [NSIDE_W-1:0] nside_ff, nside_in;
   hmni_op_type        op;
   logic [COL_W-1:0]   col;
   logic [ROW_W-1:0]   row;
   logic [CMP_W-1:0]   xw, yw, nw, n2, n3, n4, y4, kn, s4;
   logic err, y0, y1, yltn, yeqn, le3n, lt3n, lt4n, eq4m1, eq4m2, eq4, n1, nlt3;
   logic xodd, stg;
   logic               gh;
   logic [CST_W-1:0]   goff;
   hmni_form_type      form;
   hmni_xsel_type      xsel;
   logic [CST_W-1:0]   cst;
   hmni_qop_type       qop;
   logic [DVS_W-1:0]   dvs;

   assign csr_ready = 1'b1;

   always_comb begin
      nside_in = nside_ff;
      if (csr_valid) begin
         if (csr_data == '0) begin
            nside_in = NSIDE_W'(1);
         end else if (32'(csr_data) > MAX_NSIDE) begin
            nside_in = NSIDE_W'(MAX_NSIDE);
         end else begin
            nside_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nside_ff <= NSIDE_W'(1);
      end else begin
         nside_ff <= nside_in;
      end
   end

   assign op  = hmni_op_type'(req_tuser);
   assign col = req_tdata[COL_W-1:0];
   assign row = req_tdata[COL_W+ROW_W-1:COL_W];

   assign xw = CMP_W'(col);
   assign yw = CMP_W'(row);
   assign nw = CMP_W'(nside_ff);
   assign n2 = nw << 1;
   assign n3 = n2 + nw;
   assign n4 = nw << 2;
   assign y4 = yw << 2;
   // distance to the south pole row, used in the southern polar cap
   assign kn = n4 - yw;
   assign s4 = kn << 2;

   assign err   = yw > n4;
   assign y0    = yw == '0;
   assign y1    = yw == CMP_W'(1);
   assign yltn  = yw < nw;
   assign yeqn  = yw == nw;
   assign le3n  = yw <= n3;
   assign lt3n  = yw < n3;
   assign lt4n  = yw < n4;
   assign eq4m1 = yw == n4 - CMP_W'(1);
   assign eq4m2 = yw == n4 - CMP_W'(2);
   assign eq4   = yw == n4;
   assign n1    = nw == CMP_W'(1);
   assign nlt3  = nw < CMP_W'(3);
   assign xodd  = col[0];
   // stagger of equatorial rows
   assign stg   = row[0] ^ nside_ff[0];

   always_comb begin
      form = F_ZERO;
      xsel = X_ZERO;
      cst  = CST_W'(-1);
      qop  = Q_NONE;
      dvs  = DVS_W'(1);
      gh   = 1'b0;
      goff = '0;
      if (!err) begin
         unique case (op)
            OP_NODE: begin
               priority if (y0) begin
                  if (xw == CMP_W'(8)) gh = 1'b1;
                  else begin xsel = X_ONE; cst = '0; end
               end else if (yltn) begin
                  if (xw == y4) gh = 1'b1;
                  else begin form = F_POLAR_N; xsel = X_ONE; cst = CST_W'(8); end
               end else if (le3n) begin
                  if (xw == n4) gh = 1'b1;
                  else begin form = F_EQ_N; xsel = X_ONE; cst = CST_W'(8); end
               end else if (lt4n) begin
                  if (xw == s4) gh = 1'b1;
                  else begin form = F_S_N; xsel = X_ONE; cst = CST_W'(8); end
               end else begin
                  if (xw == CMP_W'(8)) gh = 1'b1;
                  else begin form = F_POLE; xsel = X_ONE; cst = CST_W'(8); end
               end
            end
            OP_UPPER: begin
               priority if (y0) begin
                  if (xw == CMP_W'(7)) gh = 1'b1;
                  else begin xsel = X_ONE; cst = CST_W'(1); end
               end else if (y1) begin
                  xsel = X_TWO; cst = '0;
               end else if (yltn || (yeqn && !nlt3)) begin
                  if (xw == y4 - CMP_W'(1)) begin
                     gh = 1'b1; goff = CST_W'(-1);
                  end else begin
                     form = F_UP_N; xsel = X_ONE; cst = CST_W'(12);
                     qop = Q_SUB; dvs = row[DVS_W-1:0];
                  end
               end else if (yeqn) begin
                  if (xw == n4 - CMP_W'(1)) begin
                     gh = 1'b1; goff = CST_W'(-1);
                  end else begin
                     form = F_UP_NS; xsel = X_HALF_UP; cst = CST_W'(12);
                  end
               end else if (le3n) begin
                  if (xw == n4 - CMP_W'(1) && !stg) begin
                     gh = 1'b1; goff = CST_W'(-1);
                  end else begin
                     form = F_UP_EQ; xsel = X_ONE; cst = CST_W'(9) - CST_W'(stg);
                  end
               end else if (lt4n && !eq4m1) begin
                  form = F_UP_S; xsel = X_ONE; cst = CST_W'(5);
                  qop = Q_ADD; dvs = kn[DVS_W-1:0];
               end else if (eq4m1) begin
                  form = F_POLE; xsel = X_TWO;
                  cst = n1 ? CST_W'(1) : CST_W'(-3);
               end else if (n1) begin
                  if (xw == CMP_W'(7)) begin
                     gh = 1'b1; goff = CST_W'(-2);
                  end else if (xodd) begin
                     form = F_POLE; xsel = X_HALF_UP; cst = '0;
                  end else begin
                     form = F_POLE; xsel = X_HALF; cst = CST_W'(4);
                  end
               end else begin
                  form = F_POLE;
                  if (xodd) begin xsel = X_ONE; cst = CST_W'(-4); end
                  else begin xsel = X_HALF_UP; cst = CST_W'(4); end
               end
            end
            OP_LOWER: begin
               priority if (y0) begin
                  if (n1 && xw == CMP_W'(7)) begin
                     gh = 1'b1; goff = CST_W'(2);
                  end else if (!xodd) begin
                     xsel = X_HALF; cst = CST_W'(8);
                  end else if (n1) begin
                     xsel = X_HALF_UP; cst = CST_W'(12);
                  end else begin
                     xsel = X_ONE; cst = CST_W'(12);
                  end
               end else if (yltn) begin
                  form = F_LO_N; xsel = X_ONE; cst = CST_W'(9);
                  qop = Q_ADD; dvs = row[DVS_W-1:0];
               end else if (yeqn && n1) begin
                  if (xw == CMP_W'(3)) begin
                     gh = 1'b1; goff = CST_W'(1);
                  end else begin
                     xsel = X_ONE; cst = CST_W'(13);
                  end
               end else if (yw == n2 && n1) begin
                  xsel = X_ONE; cst = CST_W'(16);
               end else if (lt3n && !n1) begin
                  if (xw == n4 - CMP_W'(1) && !stg) begin
                     gh = 1'b1; goff = CST_W'(1);
                  end else begin
                     form = F_LO_EQ; xsel = X_ONE; cst = CST_W'(9) - CST_W'(stg);
                  end
               end else if (eq4m2) begin
                  if (xw == CMP_W'(7)) begin
                     gh = 1'b1; goff = CST_W'(1);
                  end else begin
                     form = F_POLE; xsel = X_HALF_UP; cst = CST_W'(4);
                  end
               end else if (eq4m1) begin
                  form = F_POLE; xsel = X_TWO; cst = CST_W'(8);
               end else if (lt4n) begin
                  if (xw == s4 - CMP_W'(1)) begin
                     gh = 1'b1; goff = CST_W'(1);
                  end else begin
                     form = F_LO_S; xsel = X_ONE; cst = CST_W'(8);
                     qop = Q_SUB; dvs = kn[DVS_W-1:0];
                  end
               end else begin
                  if (xw == CMP_W'(7)) gh = 1'b1;
                  else begin form = F_POLE; xsel = X_ONE; cst = CST_W'(9); end
               end
            end
            OP_RIGHT: begin
               priority if (y0) begin
                  if ((n1 && xw == CMP_W'(7)) || (!n1 && xw >= CMP_W'(7))) begin
                     gh = 1'b1; goff = CST_W'(1);
                  end else if (xodd) begin
                     xsel = X_HALF_UP; cst = CST_W'(8);
                  end else if (n1) begin
                     xsel = X_HALF; cst = CST_W'(13);
                  end else begin
                     xsel = X_ONE; cst = CST_W'(13);
                  end
               end else if (y1) begin
                  if (xw < CMP_W'(7)) begin
                     xsel = X_TWO; cst = CST_W'(1);
                  end else begin
                     gh = 1'b1; goff = CST_W'(-1);
                  end
               end else if (yltn) begin
                  if (xw == y4 - CMP_W'(1)) gh = 1'b1;
                  else begin form = F_POLAR_N; xsel = X_ONE; cst = CST_W'(9); end
               end else if (yw == CMP_W'(3) && n1) begin
                  xsel = X_TWO; cst = CST_W'(21);
               end else if (le3n) begin
                  if (xw == n4 - CMP_W'(1)) gh = 1'b1;
                  else begin form = F_EQ_N; xsel = X_ONE; cst = CST_W'(9); end
               end else if (lt4n && !eq4m1 && !n1) begin
                  if (xw == s4 - CMP_W'(1)) gh = 1'b1;
                  else begin form = F_S_N; xsel = X_ONE; cst = CST_W'(9); end
               end else if (eq4m1) begin
                  form = F_POLE; xsel = X_TWO; cst = CST_W'(9);
               end else if (eq4) begin
                  if (xw == CMP_W'(7)) begin
                     gh = 1'b1; goff = CST_W'(-1);
                  end else if (xodd) begin
                     form = F_POLE; xsel = X_HALF_UP; cst = CST_W'(4);
                  end else begin
                     form = F_POLE; xsel = X_ONE;
                     cst = n1 ? CST_W'(1) : CST_W'(-3);
                  end
               end else begin
                  form = F_ZERO;
               end
            end
            default: begin
               form = F_ZERO;
            end
         endcase
      end
      // periodic ghost node: 12*n*n + 16 + latitude, latitude = row + offset
      if (gh) begin
         form = F_GHOST;
         xsel = X_ZERO;
         cst  = CST_W'(16) + goff;
         qop  = Q_NONE;
      end
   end

   assign req_tready     = !q_full;
   assign q_push         = req_tvalid && !q_full;
   assign q_item.form    = form;
   assign q_item.xsel    = xsel;
   assign q_item.cst     = cst;
   assign q_item.qop     = qop;
   assign q_item.dvs     = dvs;
   assign q_item.col     = col;
   assign q_item.row     = row;
   assign q_item.nside   = nside_ff;
   assign q_item.err     = err;

endmodule

### src/hmni_queue.sv
module hmni_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  hmni_pkg::hmni_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output hmni_pkg::hmni_item_type pop_item,
   output logic                    empty
);
   import hmni_pkg::*;

   hmni_item_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign full     = cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_item = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in = pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
      cnt_in  = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end

endmodule

### src/hmni_back.sv
module hmni_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  hmni_pkg::hmni_item_type           q_item,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hmni_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tuser
);
   import hmni_pkg::*;

   localparam int NST = COL_W;

   typedef struct packed {
      hmni_item_type     item;
      logic [REM_W-1:0]  rem;
      logic [COL_W-1:0]  quo;
      logic [VIDX_W-1:0] p1;
      logic [VIDX_W-1:0] p2;
      logic [VIDX_W-1:0] p3;
      logic [VIDX_W-1:0] poly;
   } hmni_stage_type;

   hmni_stage_type st_ff [NST];
   hmni_stage_type st_in [NST];
   logic [NST-1:0] vld_ff, vld_in;
   hmni_stage_type fin;
   logic adv;
   logic rsp_valid_ff, rsp_valid_in;
   logic [VIDX_W-1:0] vidx_ff, vidx_in;
   logic err_ff, err_in;
   logic [2*NSIDE_W-1:0]     p1_full;
   logic [NSIDE_W+ROW_W-1:0] p2_full;
   logic [2*ROW_W-1:0]       p3_full;
   logic [VIDX_W-1:0] xv, xt, cv, qt;

   // one restoring division step, one quotient bit per stage
   function automatic hmni_stage_type div_step(hmni_stage_type s, logic xbit);
      logic [REM_W:0] t;
      hmni_stage_type r;
      r = s;
      t = {s.rem, xbit};
      if (t >= {1'b0, s.item.dvs}) begin
         r.rem = REM_W'(t - {1'b0, s.item.dvs});
         r.quo = {s.quo[COL_W-2:0], 1'b1};
      end else begin
         r.rem = t[REM_W-1:0];
         r.quo = {s.quo[COL_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [VIDX_W-1:0] poly_of(hmni_stage_type s);
      logic [VIDX_W-1:0] a, b, c, nv, yv, r;
      a  = s.p1;
      b  = s.p2;
      c  = s.p3;
      nv = VIDX_W'(s.item.nside);
      yv = VIDX_W'(s.item.row);
      unique case (s.item.form)
         F_ZERO:    r = '0;
         F_POLE:    r = (a << 3) + (a << 2);
         F_GHOST:   r = (a << 3) + (a << 2) + yv;
         F_POLAR_N: r = (c << 1) - (yv << 1);
         F_EQ_N:    r = (b << 2) - (a << 1) - (nv << 1);
         F_S_N:     r = (b << 4) - (a << 4) - (a << 2) - (c << 1) - (nv << 3) + (yv << 1);
         F_UP_N:    r = (c << 1) - (yv << 2) - (yv << 1);
         F_UP_NS:   r = (a << 1) - (nv << 2) - (nv << 1);
         F_UP_EQ:   r = (b << 2) - (a << 1) - (nv << 2) - (nv << 1);
         F_UP_S:    r = (b << 4) - (a << 4) - (a << 2) - (c << 1) - (nv << 4) - (nv << 3)
                        + (yv << 2) + (yv << 1);
         F_LO_N:    r = (c << 1) + (yv << 1);
         F_LO_EQ:   r = (b << 2) - (a << 1) + (nv << 1);
         F_LO_S:    r = (b << 4) - (a << 4) - (a << 2) - (c << 1) + (nv << 3) - (yv << 1);
         default:   r = '0;
      endcase
      return r;
   endfunction

   assign adv   = !rsp_valid_ff || rsp_tready;
   assign q_pop = adv && !q_empty;

   assign p1_full = st_ff[0].item.nside * st_ff[0].item.nside;
   assign p2_full = st_ff[0].item.nside * st_ff[0].item.row;
   assign p3_full = st_ff[0].item.row * st_ff[0].item.row;

   always_comb begin
      st_in[0]      = '0;
      st_in[0].item = q_item;
      vld_in[0]     = !q_empty;
      for (int i = 0; i < NST-1; i++) begin
         st_in[i+1]  = div_step(st_ff[i], st_ff[i].item.col[COL_W-1-i]);
         vld_in[i+1] = vld_ff[i];
         if (i == 0) begin
            st_in[i+1].p1 = VIDX_W'(p1_full);
            st_in[i+1].p2 = VIDX_W'(p2_full);
            st_in[i+1].p3 = VIDX_W'(p3_full);
         end
         if (i == 1) begin
            st_in[i+1].poly = poly_of(st_ff[i]);
         end
      end
      fin = div_step(st_ff[NST-1], st_ff[NST-1].item.col[0]);
   end

   always_comb begin
      xv = VIDX_W'(fin.item.col);
      unique case (fin.item.xsel)
         X_ZERO:    xt = '0;
         X_ONE:     xt = xv;
         X_TWO:     xt = xv << 1;
         X_HALF:    xt = xv >> 1;
         X_HALF_UP: xt = (xv + VIDX_W'(1)) >> 1;
         default:   xt = '0;
      endcase
      cv = {{(VIDX_W-CST_W){fin.item.cst[CST_W-1]}}, fin.item.cst};
      unique case (fin.item.qop)
         Q_NONE:  qt = '0;
         Q_ADD:   qt = VIDX_W'(fin.quo);
         Q_SUB:   qt = '0 - VIDX_W'(fin.quo);
         default: qt = '0;
      endcase
      vidx_in      = adv ? fin.poly + xt + cv + qt : vidx_ff;
      err_in       = adv ? fin.item.err : err_ff;
      rsp_valid_in = adv ? vld_ff[NST-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= vld_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NST; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
      vidx_ff <= vidx_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-VIDX_W){1'b0}}, vidx_ff};
   assign rsp_tuser  = err_ff;

endmodule

### src/healpix_mesh_node_neighbour_index_unit.sv
// HEALPix mesh node / cell corner index unit.
// csr channel: writes nside (clamped to 1..MAX_NSIDE); always ready, write
//    only while the unit holds no word in flight.
// req channel: one query word per handshake; tuser carries the opcode
//    (node, upper, lower or right corner), tdata the column and row.
// rsp channel: one result word per query, in order; tdata holds the 25-bit
//    vertex index, tuser flags a row beyond the south pole (index then -1).
// The front classifies each query into a latitude band in the accepting
// cycle and writes it into a four-word queue. The back pops one word per
// cycle, unless the output is stalled, into a 13-stage pipeline: a restoring
// divider (one quotient bit per stage) runs beside the three products and
// the band polynomial, and the final sum lands in the output register.
// Throughput is one word per cycle while rsp_tready does not stall the output.
// When rsp_tready is low the back pipeline holds and the queue fills; req
// stays ready until the queue holds four words.
// Synchronous reset sets nside to 1 and empties queue and pipeline.
module healpix_mesh_node_neighbour_index_unit #(
   parameter int MAX_NSIDE = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hmni_pkg::NSIDE_W-1:0]       csr_data,     // nside
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [hmni_pkg::REQ_TDATA_W-1:0]   req_tdata,    // column[12:0], row[25:13]
   input  logic [hmni_pkg::OP_W-1:0]          req_tuser,    // opcode[1:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [hmni_pkg::RSP_TDATA_W-1:0]   rsp_tdata,    // vertex_index[24:0]
   output logic                               rsp_tuser     // row_error
);
   import hmni_pkg::*;

`include "healpix_mesh_node_neighbour_index_unit_defines.svh"

   logic          q_full, q_empty, q_push, q_pop;
   hmni_item_type q_wr_item, q_rd_item;

   hmni_front #(.MAX_NSIDE(MAX_NSIDE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_wr_item)
   );

   hmni_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_wr_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_rd_item),
      .empty     (q_empty)
   );

   hmni_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (q_rd_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `HMNI_ASSERT_NOW(a_no_overflow, q_push, !q_full, "queue written while full")
   `HMNI_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "queue read while empty")
   `HMNI_ASSERT_NOW(a_err_value, rsp_tvalid && rsp_tuser, rsp_tdata[VIDX_W-1:0] == '1, "err index")
   `HMNI_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped under stall")

endmodule

### test/tb_top.sv
module tb_top;
   import hmni_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   typedef struct {
      logic [RSP_TDATA_W-1:0] data;
      logic                   err;
   } vertex_word_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [NSIDE_W-1:0]       csr_data;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata;
   logic [OP_W-1:0]          req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     rsp_tuser;

   vertex_word_type pending_vertices[$];
   int              mismatch_count;
   int              cycle_count;
   int              hold_cycles;
   bit              quiet_sides;
   longint          model_nside;

   healpix_mesh_node_neighbour_index_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint ghost_of(longint n, longint lat);
      return 12 * n * n + 16 + lat;
   endfunction

   function automatic longint node_vertex(longint x, longint y, longint n);
      longint k;
      k = y - 3 * n;
      if (y == 0) return x != 8 ? x : ghost_of(n, y);
      if (y < n) return x != 4 * y ? 2 * y * (y - 1) + 8 + x : ghost_of(n, y);
      if (y <= 2 * n)
         return x != 4 * n ? 2 * n * (n - 1) + 4 * n * (y - n) + 8 + x : ghost_of(n, y);
      if (y <= 3 * n)
         return x != 4 * n ? 2 * n * (3 * n + 1) + 4 * n * (y - 2 * n - 1) + 8 + x
                           : ghost_of(n, y);
      if (y == 3 * n + 1 && n > 1)
         return x != 4 * (n - 1) ? 2 * n * (5 * n + 1) + 4 * n * (y - 3 * n - 1) + 8 + x
                                 : ghost_of(n, y);
      if (y < 4 * n)
         return x != 4 * (n - k) ? 2 * n * (5 * n + 1) + 4 * n * (k - 1) - 2 * k * (k - 1) + 8 + x
                                 : ghost_of(n, y);
      return x != 8 ? 12 * n * n + 8 + x : ghost_of(n, y);
   endfunction

   function automatic longint upper_vertex(longint x, longint y, longint n);
      longint stg;
      longint k;
      if (y == 0) return x != 7 ? x + 1 : ghost_of(n, 0);
      if (y == 1) return 2 * x;
      if (y < n)
         return x != 4 * y - 1 ? 2 * (y - 2) * (y - 1) + 8 + x - x / y : ghost_of(n, y - 1);
      if (y == n && n < 3)
         return x != 4 * n - 1 ? 2 * n * (n - 1) + 8 - 4 * (n - 1) + (x + 1) / 2
                               : ghost_of(n, y - 1);
      if (y == n)
         return x != 4 * n - 1 ? 2 * (n - 2) * (n - 1) + 8 + x - x / y : ghost_of(n, y - 1);
      if (y <= 3 * n) begin
         stg = (y - n) % 2;
         if (x != 4 * n - 1 || stg != 0)
            return 2 * n * (n - 1) + 8 + 4 * n * (y - n - 1) + x + 1 - stg;
         return ghost_of(n, y - 1);
      end
      if (y < 4 * n - 1) begin
         k = 4 * n - y;
         return 12 * n * n + 9 - 2 * (k + 2) * (k + 1) + x + x / k;
      end
      if (y == 4 * n - 1) return 12 * n * n + 5 - (n == 1 ? 4 : 8) + 2 * x;
      if (n == 1) begin
         if (x != 7) return 12 * n * n + 4 + ((x % 2) != 0 ? -4 + (x + 1) / 2 : x / 2);
         return ghost_of(n, 4 * n - 2);
      end
      return 12 * n * n + 8 + ((x % 2) != 0 ? x - 12 : x - 4 - x / 2);
   endfunction

   function automatic longint lower_vertex(longint x, longint y, longint n);
      longint stg;
      longint k;
      if (y == 0) begin
         if (n == 1)
            return x != 7 ? 8 + ((x % 2) != 0 ? 4 + (x + 1) / 2 : x / 2) : ghost_of(n, 2);
         return 8 + (((x + 1) % 2) != 0 ? x / 2 : 4 + x);
      end
      if (y < n) return 2 * y * (y + 1) + 9 + x + x / y;
      if (y == n && n == 1) return x != 3 ? 13 + x : ghost_of(n, 2);
      if (y == 2 * n && n == 1) return 16 + x;
      if (y < 3 * n && n > 1) begin
         stg = (y - n) % 2;
         if (x != 4 * n - 1 || stg != 0)
            return 2 * n * (n - 1) + 8 + 4 * n * (y - n + 1) + x + 1 - stg;
         return ghost_of(n, y + 1);
      end
      if (y == 4 * n - 2) return x != 7 ? 12 * n * n + 4 + (x + 1) / 2 : ghost_of(n, 4 * n - 1);
      if (y == 4 * n - 1) return 12 * n * n + 8 + 2 * x;
      if (y < 4 * n - 1) begin
         k = y - 3 * n;
         if (x != 4 * (n - k) - 1)
            return 2 * n * (5 * n + 1) + 8 + 4 * n * k - 2 * (k + 1) * k + x - x / (n - k);
         return ghost_of(n, y + 1);
      end
      return x != 7 ? 12 * n * n + 8 + x + 1 : ghost_of(n, y);
   endfunction

   function automatic longint right_vertex(longint x, longint y, longint n);
      longint k;
      k = y - 3 * n;
      if (y == 0) begin
         if (n == 1)
            return x != 7 ? ((x % 2) != 0 ? 8 + (x + 1) / 2 : 13 + x / 2) : ghost_of(n, 1);
         return x < 7 ? ((x % 2) != 0 ? 8 + (x + 1) / 2 : 13 + x) : ghost_of(n, 1);
      end
      if (y == 1) return x < 7 ? 1 + 2 * x : ghost_of(n, 0);
      if (y < n) return x != 4 * y - 1 ? 2 * y * (y - 1) + 9 + x : ghost_of(n, y);
      if (y == 3 && n == 1) return 21 + 2 * x;
      if (y <= 3 * n)
         return x != 4 * n - 1 ? 2 * n * (n - 1) + 4 * n * (y - n) + 9 + x : ghost_of(n, y);
      if (y < 4 * n - 1 && n > 1) begin
         if (x != 4 * (n - k) - 1)
            return 2 * n * (5 * n + 1) + 4 * n * (k - 1) - 2 * k * (k - 1) + 9 + x;
         return ghost_of(n, y);
      end
      if (y == 4 * n - 1) return 12 * n * n + 9 + 2 * x;
      if (y == 4 * n) begin
         if (x != 7)
            return (x % 2) != 0 ? 12 * n * n + 4 + (x + 1) / 2
                                : 12 * n * n + 4 - (n == 1 ? 3 : 7) + x;
         return ghost_of(n, y - 1);
      end
      return -1;
   endfunction

   function automatic vertex_word_type vertex_for(hmni_op_type op, logic [COL_W-1:0] col,
                                                  logic [ROW_W-1:0] row);
      vertex_word_type w;
      longint          x;
      longint          y;
      longint          v;
      x = longint'(col);
      y = longint'(row);
      w.err = 1'b0;
      if (y > 4 * model_nside) begin
         v = -1;
         w.err = 1'b1;
      end else begin
         case (op)
            OP_NODE:  v = node_vertex(x, y, model_nside);
            OP_UPPER: v = upper_vertex(x, y, model_nside);
            OP_LOWER: v = lower_vertex(x, y, model_nside);
            default:  v = right_vertex(x, y, model_nside);
         endcase
      end
      w.data = {{(RSP_TDATA_W-VIDX_W){1'b0}}, v[VIDX_W-1:0]};
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h (t=%0t)", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic send_query(hmni_op_type op, logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      int gap;
      if (!quiet_sides && $urandom_range(0, 99) < 18) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W-COL_W-ROW_W){1'b0}}, row, col};
      do @(posedge clock); while (!req_tready);
      pending_vertices.push_back(vertex_for(op, col, row));
   endtask

   task automatic drain_and_settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_nside(logic [NSIDE_W-1:0] value);
      drain_and_settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (value == 0) model_nside = 1;
      else if (value > 1024) model_nside = 1024;
      else model_nside = longint'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly rows and columns inside the mesh, some beyond, some full-width noise
   task automatic send_random_query();
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         row = ROW_W'($urandom_range(0, 32'(4 * model_nside)));
         col = COL_W'($urandom_range(0,
                  32'((4 * model_nside + 1 > 8191) ? 8191 : 4 * model_nside + 1)));
      end else if (pick < 90) begin
         row = ROW_W'($urandom_range(0, 32'(4 * model_nside)));
         col = COL_W'($urandom);
      end else if (pick < 95) begin
         row = ROW_W'((4 * model_nside + 1 > 8191) ? 8191
                      : $urandom_range(32'(4 * model_nside + 1), 8191));
         col = COL_W'($urandom_range(0, 15));
      end else begin
         row = ROW_W'($urandom);
         col = COL_W'($urandom);
      end
      send_query(hmni_op_type'($urandom_range(0, 3)), col, row);
   endtask

   task automatic test_directed_unit_mesh();
      for (int op = 0; op < 4; op++) begin
         send_query(hmni_op_type'(op), 0, 0);
         send_query(hmni_op_type'(op), 7, 1);
         send_query(hmni_op_type'(op), 3, 2);
         send_query(hmni_op_type'(op), 7, 4);
         send_query(hmni_op_type'(op), 8191, 3);
      end
      send_query(OP_NODE, 8, 0);
      send_query(OP_UPPER, 0, 5);
      send_query(OP_RIGHT, 8191, 8191);
   endtask

   task automatic test_random_phase(int count);
      repeat (count) send_random_query();
   endtask

   task automatic test_output_backpressure();
      hold_cycles = 300;
      repeat (40) send_random_query();
   endtask

   task automatic test_nside_sweep();
      logic [NSIDE_W-1:0] settings[7];
      settings = '{11'd2, 11'd3, 11'd1024, 11'd0, 11'd2047, 11'd0, 11'd1};
      settings[5] = NSIDE_W'($urandom_range(4, 1023));
      foreach (settings[i]) begin
         write_nside(settings[i]);
         test_random_phase(105);
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_data       = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = OP_NODE;
      rsp_tready     = 1'b0;
      mismatch_count = 0;
      hold_cycles    = 0;
      quiet_sides    = 1'b0;
      model_nside    = 1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_unit_mesh();
      test_random_phase(60);
      test_output_backpressure();
      quiet_sides = 1'b1;
      test_random_phase(60);
      quiet_sides = 1'b0;
      test_nside_sweep();
      drain_and_settle();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // result side ready, with random stalls and the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= quiet_sides || ($urandom_range(0, 99) >= 18);
      end
   end

   always @(posedge clock) begin
      vertex_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_vertices.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 0);
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_tdata !== want.data) report_mismatch("vertex_index", rsp_tdata, want.data);
            if (rsp_tuser !== want.err)
               report_mismatch("row_error", 32'(rsp_tuser), 32'(want.err));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial cycle_count = 0;

endmodule
